// ----- rtl/scr_pkg.sv -----
`timescale 1ns / 1ps
// scr_pkg: shared types and codes for the serial controller register file.
// No dependencies; imported by serial_controller_registers and scr_checker.
package scr_pkg;

  // Item codes
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_POLL   = 2'd2;
  localparam logic [1:0] CMD_TXDONE = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_DATA    = 2'd0;
  localparam logic [1:0] REG_STATUS  = 2'd1;
  localparam logic [1:0] REG_MODE    = 2'd2;
  localparam logic [1:0] REG_COMMAND = 2'd3;

  // Status bit positions
  localparam int ST_TR  = 0;
  localparam int ST_RD  = 1;
  localparam int ST_DSR = 7;
  localparam logic [7:0] ST_RESET = 8'h41;

  // Command bit positions
  localparam int CM_TXEN = 0;
  localparam int CM_DTR  = 1;
  localparam int CM_RXEN = 2;
  localparam int CM_FB   = 3;
  localparam int CM_OM0  = 6;

  // Operating modes, command bits 7:6
  localparam logic [1:0] OM_NORMAL   = 2'b00;
  localparam logic [1:0] OM_LOOPBACK = 2'b10;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] reg_index;
    logic [7:0] write_data;
    logic       odd_byte;
    logic       rx_valid;
    logic [7:0] rx_char;
    logic       line_accepts;
    logic       dsr_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rx_interrupt;
    logic       tx_interrupt;
    logic       tx_start;
    logic [7:0] send_char;
    logic       retry_request;
    logic       rx_taken;
    logic [7:0] line_format;
    logic [3:0] baud_code;
    logic       dtr_out;
    logic       force_break;
  } out_word_t;

endpackage

// ----- rtl/serial_controller_registers.sv -----
`timescale 1ns / 1ps
// serial_controller_registers: register file of a 2661-style serial controller.
// Depends on scr_pkg for word types, item codes and register bit positions.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------
//   in      | in_valid / in_ready  | in_word  (scr_pkg::in_word_t)
//   out     | out_valid / out_ready| out_word (scr_pkg::out_word_t)
//
// Flow: a word is captured into the input register, then the register update
// and result are computed from it and loaded into the output register;
// throughput one word per cycle while out_ready stays high.
// Reset (rst, synchronous) empties both stages and restores the registers:
// status 0x41, everything else zero, mode pointer at mode one.
// Stalls: when out_ready is low with a result waiting, the input register
// holds and in_ready drops only if the input register is also full.
module serial_controller_registers
  import scr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  // Input stage
  logic     item_valid;
  in_word_t item;
  logic     advance;

  // Architectural registers
  logic [7:0] rx_holding, rx_holding_next;
  logic [7:0] tx_holding, tx_holding_next;
  logic [7:0] status_reg, status_reg_next;
  logic [7:0] mode_one, mode_one_next;
  logic [7:0] mode_two, mode_two_next;
  logic [7:0] command_reg, command_reg_next;
  logic       mode_pointer, mode_pointer_next;

  out_word_t  result;
  logic [1:0] om;

  // Move the input word on whenever the output register is free or draining.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !item_valid || advance;
  assign om       = command_reg[7:6];

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= in_word;
    end
  end

  // Register update and result for the word in the input register.
  always_comb begin
    rx_holding_next   = rx_holding;
    tx_holding_next   = tx_holding;
    status_reg_next   = status_reg;
    mode_one_next     = mode_one;
    mode_two_next     = mode_two;
    command_reg_next  = command_reg;
    mode_pointer_next = mode_pointer;
    result            = '0;

    unique case (item.command)
      CMD_READ: begin
        unique case (item.reg_index)
          REG_DATA: begin
            result.read_data       = rx_holding;
            status_reg_next[ST_RD] = 1'b0;
          end
          REG_STATUS: begin
            // Sample DSR into the status byte, then return it.
            status_reg_next[ST_DSR] = item.dsr_in;
            result.read_data        = status_reg_next;
          end
          REG_MODE: begin
            result.read_data  = mode_pointer ? mode_two : mode_one;
            mode_pointer_next = !mode_pointer;
          end
          REG_COMMAND: begin
            result.read_data  = command_reg;
            mode_pointer_next = !mode_pointer;
          end
        endcase
      end
      CMD_WRITE: begin
        // Drop upper-byte writes entirely.
        if (!item.odd_byte) begin
          unique case (item.reg_index)
            REG_DATA: begin
              if (command_reg[CM_TXEN]) begin
                tx_holding_next        = item.write_data;
                status_reg_next[ST_TR] = 1'b0;
                result.tx_start        = 1'b1;
              end
            end
            REG_STATUS: begin
            end
            REG_MODE: begin
              if (mode_pointer) begin
                mode_two_next = item.write_data;
              end else begin
                mode_one_next = item.write_data;
              end
              mode_pointer_next = !mode_pointer;
            end
            REG_COMMAND: begin
              command_reg_next = item.write_data;
              if (!item.write_data[CM_RXEN]) begin
                status_reg_next[ST_RD] = 1'b0;
              end
              // Transmit ready only with TX enabled and no echo/remote loop.
              status_reg_next[ST_TR] = item.write_data[CM_TXEN] && !item.write_data[CM_OM0];
            end
          endcase
        end
      end
      CMD_POLL: begin
        if (om == OM_NORMAL && command_reg[CM_RXEN] && !status_reg[ST_RD] &&
            item.rx_valid) begin
          rx_holding_next        = item.rx_char;
          status_reg_next[ST_RD] = 1'b1;
          result.rx_interrupt    = 1'b1;
          result.rx_taken        = 1'b1;
        end
      end
      CMD_TXDONE: begin
        if (om == OM_NORMAL) begin
          result.send_char = tx_holding;
        end
        if (om == OM_NORMAL && !item.line_accepts) begin
          // Refused by the line: flag a retry and leave all state alone.
          result.retry_request = 1'b1;
        end else begin
          status_reg_next[ST_TR] = 1'b1;
          result.tx_interrupt    = 1'b1;
          if (om == OM_LOOPBACK) begin
            rx_holding_next        = tx_holding;
            status_reg_next[ST_RD] = 1'b1;
            result.rx_interrupt    = 1'b1;
          end
        end
      end
    endcase

    // Line parameters reflect the registers after this word.
    result.line_format = mode_one_next;
    result.baud_code   = mode_two_next[3:0];
    result.dtr_out     = command_reg_next[CM_DTR];
    result.force_break = command_reg_next[CM_FB];
  end

  // Commit the update and load the output register together.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      rx_holding   <= '0;
      tx_holding   <= '0;
      status_reg   <= ST_RESET;
      mode_one     <= '0;
      mode_two     <= '0;
      command_reg  <= '0;
      mode_pointer <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) begin
        rx_holding   <= rx_holding_next;
        tx_holding   <= tx_holding_next;
        status_reg   <= status_reg_next;
        mode_one     <= mode_one_next;
        mode_two     <= mode_two_next;
        command_reg  <= command_reg_next;
        mode_pointer <= mode_pointer_next;
      end
    end
    if (advance && item_valid) begin
      out_word <= result;
    end
  end

endmodule

// ----- rtl/scr_checker.sv -----
`timescale 1ns / 1ps
// scr_checker: port-level checks for serial_controller_registers, plus bind.
// Depends on scr_pkg for the word types.
module scr_checker
  import scr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A refused transmit changes nothing else.
  a_retry_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.retry_request |->
      !out_word.tx_interrupt && !out_word.rx_interrupt && !out_word.tx_start &&
      !out_word.rx_taken && out_word.read_data == 8'd0)
    else $error("retry request combined with other activity");

  a_taken_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.rx_taken |->
      out_word.rx_interrupt && !out_word.tx_interrupt && out_word.send_char == 8'd0)
    else $error("received character taken without receiver interrupt");

  a_start_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.tx_start |->
      !out_word.rx_interrupt && !out_word.tx_interrupt && out_word.read_data == 8'd0)
    else $error("transmit start combined with interrupt or read data");

endmodule

bind serial_controller_registers scr_checker u_scr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
